// ----- src/gcc_pkg.sv -----
`default_nettype none

package gcc_pkg;

  // Sizes of the block
  localparam int MAX_COIN_TYPES = 7;
  localparam int AMOUNT_W       = 14;
  localparam int TYPE_W         = 3;
  localparam int STATUS_W       = 2;
  localparam int ADDR_W         = 5;
  localparam int DATA_W         = 32;

  // One quotient bit per divider step
  localparam int DIV_STEPS = AMOUNT_W;
  localparam int STEP_W    = $clog2(DIV_STEPS);

  typedef logic [AMOUNT_W-1:0] amount_t;
  typedef logic [TYPE_W-1:0]   type_t;
  typedef logic [MAX_COIN_TYPES-1:0][AMOUNT_W-1:0] denom_arr_t;

  localparam amount_t AMOUNT_LIMIT = 14'd10000;

  // Register map (index = paddr / 4)
  localparam type_t REG_NUM_TYPES  = 3'd0;
  localparam type_t REG_DENOM_BASE = 3'd1;

  localparam type_t      NUM_TYPES_RESET = 3'd7;
  localparam denom_arr_t DENOM_RESET     = {14'd100, 14'd50, 14'd20, 14'd10,
                                            14'd5, 14'd2, 14'd1};

  typedef enum logic [STATUS_W-1:0] {
    STATUS_OK    = 2'd0,
    STATUS_ZERO  = 2'd1,
    STATUS_RANGE = 2'd2
  } status_t;

  // Token that walks down the cell chain
  typedef struct packed {
    logic    vld;
    logic    done;   // split already ended above this cell
    logic    extra;  // one more smallest coin owed
    amount_t rem;
  } tok_t;

  // Static setup of one cell
  typedef struct packed {
    amount_t denom;
    amount_t denom0;
    logic    in_use;
    logic    bottom;
  } cell_cfg_t;

  typedef enum logic [1:0] {
    CELL_IDLE,
    CELL_DIV,
    CELL_FIN
  } cell_state_t;

  typedef enum logic [1:0] {
    TOP_IDLE,
    TOP_RUN,
    TOP_EMIT
  } top_state_t;

endpackage

`default_nettype wire

// ----- src/gcc_cell.sv -----
`default_nettype none

module gcc_cell (
  input  logic               clk,
  input  logic               rst,
  input  gcc_pkg::cell_cfg_t cfg,
  input  gcc_pkg::tok_t      tok_in,
  output gcc_pkg::tok_t      tok_out,
  output gcc_pkg::amount_t   count
);

  localparam int AW = gcc_pkg::AMOUNT_W;
  localparam logic [gcc_pkg::STEP_W-1:0] LAST_STEP = gcc_pkg::STEP_W'(gcc_pkg::DIV_STEPS - 1);

  gcc_pkg::cell_state_t state, state_next;
  gcc_pkg::tok_t        tok_next;
  gcc_pkg::amount_t     count_next;

  gcc_pkg::amount_t            acc;
  gcc_pkg::amount_t            quo;
  logic [gcc_pkg::STEP_W-1:0]  step;
  logic                        mode_ge;

  logic             under, skip, start, ge;
  gcc_pkg::amount_t num;
  logic [AW:0]      trial;
  logic             fits;
  gcc_pkg::amount_t acc_step, quo_step, rem_v, quo_inc;

  // Classify the arriving token
  assign under = !tok_in.done && cfg.in_use &&
                 ((tok_in.rem < cfg.denom0) || (cfg.denom == '0 && cfg.bottom));
  assign skip  = tok_in.done || !cfg.in_use || (!under && cfg.denom == '0);
  assign start = tok_in.vld && !under && !skip;
  assign ge    = cfg.denom >= cfg.denom0;
  assign num   = ge ? tok_in.rem - AW'(1) : tok_in.rem - cfg.denom0;

  // One restoring divide step
  assign trial    = {acc, quo[AW-1]};
  assign fits     = trial >= {1'b0, cfg.denom};
  assign acc_step = fits ? AW'(trial - {1'b0, cfg.denom}) : trial[AW-1:0];
  assign quo_step = {quo[AW-2:0], fits};

  assign rem_v   = acc + AW'(1);
  assign quo_inc = quo + AW'(1);

  // Next state
  always_comb begin
    state_next = state;
    unique case (state)
      gcc_pkg::CELL_IDLE: if (start) state_next = gcc_pkg::CELL_DIV;
      gcc_pkg::CELL_DIV:  if (step == LAST_STEP) state_next = gcc_pkg::CELL_FIN;
      gcc_pkg::CELL_FIN:  state_next = gcc_pkg::CELL_IDLE;
      default:            state_next = gcc_pkg::CELL_IDLE;
    endcase
  end

  // Token and count handed on
  always_comb begin
    tok_next   = '0;
    count_next = count;
    unique case (state)
      gcc_pkg::CELL_IDLE: begin
        if (tok_in.vld && skip) begin
          tok_next   = tok_in;
          count_next = '0;
        end else if (tok_in.vld && under) begin
          tok_next       = tok_in;
          tok_next.done  = 1'b1;
          tok_next.extra = 1'b1;
          count_next     = '0;
        end
      end
      gcc_pkg::CELL_FIN: begin
        tok_next.vld = 1'b1;
        tok_next.rem = rem_v;
        if (mode_ge) begin
          if (rem_v < cfg.denom0) begin
            count_next     = quo;
            tok_next.done  = 1'b1;
            tok_next.extra = 1'b1;
          end else if (rem_v == cfg.denom) begin
            count_next    = quo_inc;
            tok_next.done = 1'b1;
          end else begin
            count_next = quo;
          end
        end else begin
          // coin below the smallest one: run out to the smallest and round up
          count_next     = quo_inc;
          tok_next.done  = 1'b1;
          tok_next.extra = 1'b1;
        end
      end
      default: ;
    endcase
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= gcc_pkg::CELL_IDLE;
      tok_out <= '0;
    end else begin
      state   <= state_next;
      tok_out <= tok_next;
    end
  end

  // Divider datapath and count
  always_ff @(posedge clk) begin
    count <= count_next;
    if (state == gcc_pkg::CELL_IDLE && start) begin
      acc     <= '0;
      quo     <= num;
      step    <= '0;
      mode_ge <= ge;
    end else if (state == gcc_pkg::CELL_DIV) begin
      acc  <= acc_step;
      quo  <= quo_step;
      step <= step + gcc_pkg::STEP_W'(1);
    end
  end

endmodule

`default_nettype wire

// ----- src/gcc_cfg.sv -----
`default_nettype none

module gcc_cfg (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [gcc_pkg::ADDR_W-1:0]  paddr,
  input  logic [gcc_pkg::DATA_W-1:0]  pwdata,
  output logic [gcc_pkg::DATA_W-1:0]  prdata,
  output gcc_pkg::type_t              num_types,
  output gcc_pkg::denom_arr_t         denom
);

  gcc_pkg::type_t idx;
  gcc_pkg::type_t didx;
  logic           wr;

  assign idx  = paddr[gcc_pkg::ADDR_W-1:2];
  assign didx = idx - gcc_pkg::REG_DENOM_BASE;
  assign wr   = psel && penable && pwrite;

  // Register writes
  always_ff @(posedge clk) begin
    if (rst) begin
      num_types <= gcc_pkg::NUM_TYPES_RESET;
      denom     <= gcc_pkg::DENOM_RESET;
    end else if (wr) begin
      if (idx == gcc_pkg::REG_NUM_TYPES) begin
        num_types <= pwdata[gcc_pkg::TYPE_W-1:0];
      end else begin
        denom[didx] <= pwdata[gcc_pkg::AMOUNT_W-1:0];
      end
    end
  end

  // Read back
  always_comb begin
    if (idx == gcc_pkg::REG_NUM_TYPES) begin
      prdata = gcc_pkg::DATA_W'(num_types);
    end else begin
      prdata = gcc_pkg::DATA_W'(denom[didx]);
    end
  end

endmodule

`default_nettype wire

// ----- src/greedy_coin_change_unit.sv -----
`default_nettype none

// Greedy coin splitter.
// Input channel (in_valid/in_stall, amount): one amount per beat. Output
// channel (out_valid/out_stall): one beat per coin type in use, smallest
// coin first, with coin_type, coin_count, status and last; last marks the
// final beat of an amount. A zero amount or one above 10000 gives a single
// beat with status set and a zero count.
// The amount walks down a row of seven cells, largest coin at the top. A
// cell not in use, or reached after the split has ended, hands the amount
// on in the next cycle; a cell that divides captures the amount, works
// out 14 quotient bits, then finishes. Once the split is done, the beats
// are registered one per cycle while the receiver takes them.
// A new amount is taken only once all beats of the previous one have been
// loaded into the output register.
// Registers sit on an APB-style port at byte address 4*i: num_types, then
// denom_0..denom_6. Write them only while the block is idle. Reset restores
// the default coin set (1, 2, 5, 10, 20, 50, 100, seven types in use) and
// empties the cell row. While out_stall is high the output beat holds and
// the remaining beats wait.

module greedy_coin_change_unit (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        in_valid,
  output logic                        in_stall,
  input  logic [gcc_pkg::AMOUNT_W-1:0] amount,
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic [gcc_pkg::TYPE_W-1:0]   coin_type,
  output logic [gcc_pkg::AMOUNT_W-1:0] coin_count,
  output logic [gcc_pkg::STATUS_W-1:0] status,
  output logic                        last,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [gcc_pkg::ADDR_W-1:0]   paddr,
  input  logic [gcc_pkg::DATA_W-1:0]   pwdata,
  output logic [gcc_pkg::DATA_W-1:0]   prdata,
  output logic                        pready
);

  localparam int NT = gcc_pkg::MAX_COIN_TYPES;
  localparam int AW = gcc_pkg::AMOUNT_W;
  localparam int TW = gcc_pkg::TYPE_W;

  gcc_pkg::type_t      num_types;
  gcc_pkg::denom_arr_t denom;
  gcc_pkg::type_t      n_eff;
  gcc_pkg::type_t      top_idx;

  gcc_pkg::top_state_t state, state_next;
  gcc_pkg::tok_t       chain_tok [0:NT];
  gcc_pkg::amount_t    cnt       [0:NT-1];
  logic [NT-1:0]       cell_vld;

  gcc_pkg::status_t err_status;
  logic             is_err;
  logic             extra0;
  gcc_pkg::type_t   idx;

  logic             accept, amount_ok, load_out, emit_last;
  gcc_pkg::amount_t beat_count;

  assign pready = 1'b1;

  gcc_cfg u_cfg (
    .clk       (clk),
    .rst       (rst),
    .psel      (psel),
    .penable   (penable),
    .pwrite    (pwrite),
    .paddr     (paddr),
    .pwdata    (pwdata),
    .prdata    (prdata),
    .num_types (num_types),
    .denom     (denom)
  );

  // Clamp the number of coin types
  always_comb begin
    if (num_types == '0) begin
      n_eff = TW'(1);
    end else if (num_types > TW'(NT)) begin
      n_eff = TW'(NT);
    end else begin
      n_eff = num_types;
    end
  end
  assign top_idx = n_eff - TW'(1);

  assign accept    = in_valid && !in_stall;
  assign amount_ok = (amount != '0) && (amount <= gcc_pkg::AMOUNT_LIMIT);

  // Inject the amount at the top of the row
  assign chain_tok[NT] = '{vld: accept && amount_ok, done: 1'b0, extra: 1'b0, rem: amount};

  // Row of cells, largest coin at the top
  for (genvar k = 0; k < NT; k++) begin : g_cell
    gcc_pkg::cell_cfg_t ccfg;
    always_comb begin
      ccfg.denom  = denom[k];
      ccfg.denom0 = denom[0];
      ccfg.in_use = TW'(k) < n_eff;
      ccfg.bottom = (k == 0);
    end
    gcc_cell u_cell (
      .clk     (clk),
      .rst     (rst),
      .cfg     (ccfg),
      .tok_in  (chain_tok[k+1]),
      .tok_out (chain_tok[k]),
      .count   (cnt[k])
    );
    assign cell_vld[k] = chain_tok[k].vld;
  end

  // Next state
  always_comb begin
    state_next = state;
    unique case (state)
      gcc_pkg::TOP_IDLE: begin
        if (accept) state_next = amount_ok ? gcc_pkg::TOP_RUN : gcc_pkg::TOP_EMIT;
      end
      gcc_pkg::TOP_RUN: if (chain_tok[0].vld) state_next = gcc_pkg::TOP_EMIT;
      gcc_pkg::TOP_EMIT: if (load_out && emit_last) state_next = gcc_pkg::TOP_IDLE;
      default: state_next = gcc_pkg::TOP_IDLE;
    endcase
  end

  // Handshake and beat selection
  always_comb begin
    in_stall   = (state != gcc_pkg::TOP_IDLE);
    load_out   = (state == gcc_pkg::TOP_EMIT) && (!out_valid || !out_stall);
    emit_last  = is_err || (idx == top_idx);
    if (is_err) begin
      beat_count = '0;
    end else if (idx == '0) begin
      beat_count = cnt[0] + AW'(extra0);
    end else begin
      beat_count = cnt[idx];
    end
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= gcc_pkg::TOP_IDLE;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (load_out) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Item bookkeeping and output beat
  always_ff @(posedge clk) begin
    if (accept) begin
      idx    <= '0;
      is_err <= !amount_ok;
      if (amount == '0) begin
        err_status <= gcc_pkg::STATUS_ZERO;
      end else if (!amount_ok) begin
        err_status <= gcc_pkg::STATUS_RANGE;
      end else begin
        err_status <= gcc_pkg::STATUS_OK;
      end
    end
    if (state == gcc_pkg::TOP_RUN && chain_tok[0].vld) begin
      extra0 <= chain_tok[0].extra;
    end
    if (load_out) begin
      coin_type  <= is_err ? '0 : idx;
      coin_count <= beat_count;
      status     <= err_status;
      last       <= emit_last;
      idx        <= idx + TW'(1);
    end
  end

  // Only one amount is ever in the row
  a_one_token: assert property (@(posedge clk) disable iff (rst) $onehot0(cell_vld))
    else $error("more than one token in the cell row");

  // Row is empty whenever the block waits for an amount
  a_idle_empty: assert property (@(posedge clk) disable iff (rst)
    state == gcc_pkg::TOP_IDLE |-> cell_vld == '0)
    else $error("token in the cell row while idle");

  // Split finishes only while running
  a_done_in_run: assert property (@(posedge clk) disable iff (rst)
    chain_tok[0].vld |-> state == gcc_pkg::TOP_RUN)
    else $error("split finished outside of run");

  // An accepted amount always leaves idle
  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall |=> state != gcc_pkg::TOP_IDLE)
    else $error("accepted amount did not start");

endmodule

`default_nettype wire

// ----- tb/sv/tb_greedy_coin_change_unit.sv -----
`timescale 1ns / 100ps

module tb_greedy_coin_change_unit;

  // One expected output beat, with the amount it came from for messages
  typedef struct packed {
    gcc_pkg::amount_t src_amount;
    gcc_pkg::type_t   coin_type;
    gcc_pkg::amount_t coin_count;
    gcc_pkg::status_t status;
    logic             last;
  } coin_beat_t;

  logic                         clk       = 1'b0;
  logic                         rst       = 1'b1;
  logic                         in_valid  = 1'b0;
  logic                         in_stall;
  gcc_pkg::amount_t             amount    = '0;
  logic                         out_valid;
  logic                         out_stall = 1'b0;
  gcc_pkg::type_t               coin_type;
  gcc_pkg::amount_t             coin_count;
  logic [gcc_pkg::STATUS_W-1:0] status;
  logic                         last;
  logic                         psel      = 1'b0;
  logic                         penable   = 1'b0;
  logic                         pwrite    = 1'b0;
  logic [gcc_pkg::ADDR_W-1:0]   paddr     = '0;
  logic [gcc_pkg::DATA_W-1:0]   pwdata    = '0;
  logic [gcc_pkg::DATA_W-1:0]   prdata;
  logic                         pready;

  // Local copy of the coin set, changed only while the block is idle
  logic [gcc_pkg::TYPE_W-1:0] cfg_types;
  gcc_pkg::amount_t           cfg_denom [gcc_pkg::MAX_COIN_TYPES];

  gcc_pkg::amount_t pending_amounts [$];
  coin_beat_t       beats_due [$];
  int               mismatch_count = 0;
  int               send_gap = 0;
  int               stall_left = 0;
  logic             calm = 1'b0;

  greedy_coin_change_unit i_dut (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .amount     (amount),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .coin_type  (coin_type),
    .coin_count (coin_count),
    .status     (status),
    .last       (last),
    .psel       (psel),
    .penable    (penable),
    .pwrite     (pwrite),
    .paddr      (paddr),
    .pwdata     (pwdata),
    .prdata     (prdata),
    .pready     (pready)
  );

  always #4 clk = ~clk;

  task automatic report_mismatch(input string msg);
    $display("[%0t] mismatch: %s", $realtime, msg);
    mismatch_count++;
  endtask

  // Mostly short gaps, a few long ones; none in calm phases
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (calm || r < 55) begin
      return 0;
    end
    if (r < 90) begin
      return $urandom_range(1, 3);
    end
    return $urandom_range(8, 40);
  endfunction

  // Greedy split of one amount into the beats the block must return
  task automatic split_amount(input gcc_pkg::amount_t amt);
    int               counts [gcc_pkg::MAX_COIN_TYPES];
    int               types;
    int               idx;
    gcc_pkg::amount_t rest;
    logic             done;
    coin_beat_t       beat;
    types = (cfg_types == 0) ? 1 : int'(cfg_types);
    if (types > gcc_pkg::MAX_COIN_TYPES) begin
      types = gcc_pkg::MAX_COIN_TYPES;
    end
    beat.src_amount = amt;
    if (amt == 0 || amt > gcc_pkg::AMOUNT_LIMIT) begin
      beat.coin_type  = '0;
      beat.coin_count = '0;
      beat.status     = (amt == 0) ? gcc_pkg::STATUS_ZERO : gcc_pkg::STATUS_RANGE;
      beat.last       = 1'b1;
      beats_due.push_back(beat);
      return;
    end
    foreach (counts[k]) counts[k] = 0;
    rest = amt;
    idx  = types - 1;
    done = 1'b0;
    while (!done) begin
      if (rest < cfg_denom[0]) begin
        // leftover below the smallest coin: round up with one more
        counts[0]++;
        done = 1'b1;
      end else if (cfg_denom[idx] == 0) begin
        // skip an empty coin; an empty smallest coin takes the rest
        if (idx == 0) begin
          counts[0]++;
          done = 1'b1;
        end else begin
          idx--;
        end
      end else if (rest == cfg_denom[idx]) begin
        counts[idx]++;
        done = 1'b1;
      end else if (rest > cfg_denom[idx]) begin
        counts[idx]++;
        rest = rest - cfg_denom[idx];
      end else if (idx == 0) begin
        counts[0]++;
        done = 1'b1;
      end else begin
        idx--;
      end
    end
    for (int k = 0; k < types; k++) begin
      beat.coin_type  = gcc_pkg::type_t'(k);
      beat.coin_count = gcc_pkg::amount_t'(counts[k]);
      beat.status     = gcc_pkg::STATUS_OK;
      beat.last       = (k == types - 1);
      beats_due.push_back(beat);
    end
  endtask

  // Feed amounts from the pending queue, with random gaps after each beat
  always @(posedge clk) begin : drive_amounts
    if (rst) begin
      in_valid <= 1'b0;
      send_gap <= 0;
    end else if (!in_valid || !in_stall) begin
      if (in_valid) begin
        split_amount(amount);
      end
      if (send_gap != 0) begin
        in_valid <= 1'b0;
        send_gap <= send_gap - 1;
      end else if (pending_amounts.size() != 0) begin
        in_valid <= 1'b1;
        amount   <= pending_amounts.pop_front();
        send_gap <= pick_gap();
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Check each output beat against the oldest expectation; stall at random
  always @(posedge clk) begin : watch_beats
    coin_beat_t want;
    int         hold;
    if (!rst) begin
      if (out_valid && !out_stall) begin
        if (beats_due.size() == 0) begin
          report_mismatch($sformatf("unexpected beat, coin_type %0d coin_count %0d",
                                    coin_type, coin_count));
        end else begin
          want = beats_due.pop_front();
          if (coin_type !== want.coin_type) begin
            report_mismatch($sformatf("amount %0d: coin_type %0d, want %0d",
                                      want.src_amount, coin_type, want.coin_type));
          end
          if (coin_count !== want.coin_count) begin
            report_mismatch($sformatf("amount %0d type %0d: coin_count %0d, want %0d",
                                      want.src_amount, want.coin_type, coin_count,
                                      want.coin_count));
          end
          if (status !== want.status) begin
            report_mismatch($sformatf("amount %0d: status %0d, want %0d",
                                      want.src_amount, status, want.status));
          end
          if (last !== want.last) begin
            report_mismatch($sformatf("amount %0d type %0d: last %0b, want %0b",
                                      want.src_amount, want.coin_type, last, want.last));
          end
        end
      end
      if (stall_left != 0) begin
        out_stall  <= 1'b1;
        stall_left <= stall_left - 1;
      end else begin
        hold = ($urandom_range(0, 99) < 25) ? pick_gap() : 0;
        out_stall  <= (hold != 0);
        stall_left <= (hold != 0) ? hold - 1 : 0;
      end
    end
  end

  // Write num_types and all seven denominations over the register port
  task automatic load_coins(input logic [gcc_pkg::TYPE_W-1:0] types,
                            input gcc_pkg::denom_arr_t set);
    logic [gcc_pkg::DATA_W-1:0] value;
    for (int k = 0; k <= gcc_pkg::MAX_COIN_TYPES; k++) begin
      if (k == gcc_pkg::REG_NUM_TYPES) begin
        value = gcc_pkg::DATA_W'(types);
      end else begin
        value = gcc_pkg::DATA_W'(set[k - gcc_pkg::REG_DENOM_BASE]);
      end
      @(posedge clk);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b1;
      paddr   <= gcc_pkg::ADDR_W'(4 * k);
      pwdata  <= value;
      @(posedge clk);
      penable <= 1'b1;
      do @(posedge clk); while (!pready);
      psel    <= 1'b0;
      penable <= 1'b0;
      pwrite  <= 1'b0;
      if (k == gcc_pkg::REG_NUM_TYPES) begin
        cfg_types = types;
      end else begin
        cfg_denom[k - gcc_pkg::REG_DENOM_BASE] = set[k - gcc_pkg::REG_DENOM_BASE];
      end
    end
    @(negedge clk);
  endtask

  // Random amounts: mostly in range, some small, some zero or too large
  task automatic queue_random(input int count, input int span);
    int r;
    repeat (count) begin
      r = $urandom_range(0, 99);
      if (r < 5) begin
        pending_amounts.push_back('0);
      end else if (r < 10) begin
        pending_amounts.push_back(gcc_pkg::amount_t'($urandom_range(10001, 16383)));
      end else if (r < 40) begin
        pending_amounts.push_back(gcc_pkg::amount_t'($urandom_range(1, span)));
      end else begin
        pending_amounts.push_back(gcc_pkg::amount_t'($urandom_range(1, 10000)));
      end
    end
  endtask

  // Hold until every queued amount is taken and every beat has come back
  task automatic drain_beats();
    do @(negedge clk);
    while (pending_amounts.size() != 0 || in_valid || beats_due.size() != 0);
  endtask

  initial begin : run_test
    gcc_pkg::amount_t    default_amounts [15];
    gcc_pkg::amount_t    odd_amounts [6];
    gcc_pkg::denom_arr_t coins;
    int                  v;
    default_amounts = '{0, 1, 3, 4, 8, 99, 100, 188, 9999, 10000,
                        10001, 16383, 8191, 5461, 10922};
    odd_amounts     = '{1, 2, 13, 14, 10000, 136};
    cfg_types = gcc_pkg::NUM_TYPES_RESET;
    for (int k = 0; k < gcc_pkg::MAX_COIN_TYPES; k++) cfg_denom[k] = gcc_pkg::DENOM_RESET[k];
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Default coin set: field extremes and both status cases
    foreach (default_amounts[k]) pending_amounts.push_back(default_amounts[k]);
    drain_beats();

    // Uneven coins, so leftovers below the smallest coin round up
    load_coins(3'd7, {14'd10000, 14'd125, 14'd60, 14'd25, 14'd11, 14'd7, 14'd3});
    foreach (odd_amounts[k]) pending_amounts.push_back(odd_amounts[k]);
    queue_random(20, 300);
    drain_beats();

    // Single unit coin: largest possible count
    load_coins(3'd1, {14'd9, 14'd8, 14'd7, 14'd6, 14'd5, 14'd4, 14'd1});
    pending_amounts.push_back(gcc_pkg::amount_t'(10000));
    pending_amounts.push_back(gcc_pkg::amount_t'(1));
    queue_random(8, 50);
    drain_beats();

    // Zero types in use acts as one
    load_coins(3'd0, {14'd90, 14'd80, 14'd70, 14'd60, 14'd50, 14'd40, 14'd7});
    queue_random(10, 40);
    drain_beats();

    // Empty coins, the smallest one among them
    load_coins(3'd5, {14'd0, 14'd0, 14'd30, 14'd9, 14'd0, 14'd4, 14'd0});
    queue_random(15, 100);
    drain_beats();

    // Scrambled coin sets with any 14-bit value
    repeat (3) begin
      for (int k = 0; k < gcc_pkg::MAX_COIN_TYPES; k++) begin
        v = $urandom_range(0, 99);
        if (v < 15) begin
          coins[k] = '0;
        end else if (v < 25) begin
          coins[k] = 14'h3FFF;
        end else if (v < 65) begin
          coins[k] = gcc_pkg::amount_t'($urandom_range(1, 200));
        end else begin
          coins[k] = gcc_pkg::amount_t'($urandom_range(1, 16383));
        end
      end
      load_coins(gcc_pkg::TYPE_W'($urandom_range(0, 7)), coins);
      queue_random(8, 400);
      drain_beats();
    end

    // Random ascending coin sets
    repeat (3) begin
      v = $urandom_range(1, 9);
      for (int k = 0; k < gcc_pkg::MAX_COIN_TYPES; k++) begin
        coins[k] = gcc_pkg::amount_t'(v);
        v = v + $urandom_range(1, v + 20);
        if (v > 10000) begin
          v = 10000;
        end
      end
      load_coins(gcc_pkg::TYPE_W'($urandom_range(1, 7)), coins);
      queue_random(12, 500);
      drain_beats();
    end

    // Back to the default set with no idling on either side
    calm = 1'b1;
    load_coins(gcc_pkg::NUM_TYPES_RESET, gcc_pkg::DENOM_RESET);
    queue_random(20, 300);
    drain_beats();
    calm = 1'b0;

    // Catch any late, unexpected beat
    repeat (150) @(negedge clk);
    if (mismatch_count == 0 && beats_due.size() == 0) begin
      $display("greedy_coin_change_unit test passed");
    end else begin
      $display("greedy_coin_change_unit test failed");
    end
    $finish;
  end

  initial begin : watchdog
    #3200000;
    $display("greedy_coin_change_unit test failed");
    $finish;
  end

endmodule
